### hdl/mi3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// Types, widths and constant tables shared by the 3x3 inverse pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int EW     = 24;            // element width, Q8.16
  localparam int PW     = 2 * EW;        // element product
  localparam int CW     = PW + 1;        // cofactor
  localparam int AMW    = PW;            // cofactor magnitude
  localparam int CSPLIT = 25;            // low slice of a cofactor for the det products
  localparam int DETW   = 74;            // determinant, signed
  localparam int MAGW   = 72;            // determinant magnitude
  localparam int DENW   = MAGW + 1;      // twice the magnitude
  localparam int FRACSH = 33;            // numerator shift
  localparam int NW     = AMW + FRACSH;  // numerator width
  localparam int QW     = 25;            // quotient bits resolved per lane
  localparam int REMW   = DENW;          // partial remainder
  localparam int NLANE  = 9;

  // input register, products, cofactors, four det stages, lane prep, steps, lane result
  localparam int LAT_CORE = 3 + 4 + QW + 2;

  localparam logic signed [EW-1:0] Q_MAX     = 24'sh7FFFFF;
  localparam logic signed [EW-1:0] Q_MIN     = 24'sh800000;
  localparam logic [QW-1:0]        Q_POS_LIM = 25'h07FFFFF;
  localparam logic [QW-1:0]        Q_NEG_LIM = 25'h0800000;

  typedef logic signed [EW-1:0]   elem_t;
  typedef logic signed [PW-1:0]   prod_t;
  typedef logic signed [CW-1:0]   cof_t;
  typedef logic signed [DETW-1:0] det_t;
  typedef logic [MAGW-1:0]        dmag_t;

  typedef struct packed {
    elem_t val;
    logic  sat;
    logic  sing;
  } res_t;

  // operand pairs of the 18 minor products; cofactor k = prod 2k - prod 2k+1
  localparam int MUL_L [18] = '{4, 5, 5, 3, 3, 4, 2, 1, 0, 2, 1, 0, 1, 2, 2, 0, 0, 1};
  localparam int MUL_R [18] = '{8, 7, 6, 8, 7, 6, 7, 8, 8, 6, 6, 7, 5, 4, 3, 5, 4, 3};

endpackage

### hdl/mi3_cofactor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_cofactor
// Input register, the eighteen minor products and the nine cofactors.
// ----------------------------------------------------------------------------
module mi3_cofactor import mi3_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  elem_t a   [9],
  output cof_t  cof [9],
  output elem_t row0 [3]
);

  elem_t x    [9];
  prod_t p    [18];
  elem_t r0_1 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      x <= a;
      for (int i = 0; i < 3; i++) begin
        r0_1[i] <= x[i];
        row0[i] <= r0_1[i];
      end
    end
  end

  for (genvar j = 0; j < 18; j++) begin : g_prod
    always_ff @(posedge clk) begin
      if (en) begin
        p[j] <= x[MUL_L[j]] * x[MUL_R[j]];
      end
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_cof
    always_ff @(posedge clk) begin
      if (en) begin
        cof[k] <= CW'(p[2*k]) - CW'(p[2*k+1]);
      end
    end
  end

endmodule

### hdl/mi3_det.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_det
// Determinant from row 0 and its cofactors, split into narrow products,
// then magnitude, sign and zero test. Cofactors ride along to stay aligned.
// ----------------------------------------------------------------------------
module mi3_det import mi3_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  cof_t  cof   [9],
  input  elem_t row0  [3],
  output cof_t  cof_d [9],
  output dmag_t dmag,
  output logic  dneg,
  output logic  zero
);

  logic signed [CW:0]   plo  [3];
  prod_t                phi  [3];
  det_t                 term [3];
  det_t                 det;
  cof_t                 c3 [9];
  cof_t                 c4 [9];
  cof_t                 c5 [9];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        plo[j] <= row0[j] * $signed({1'b0, cof[j][CSPLIT-1:0]});
        phi[j] <= row0[j] * $signed(cof[j][CW-1:CSPLIT]);
        term[j] <= $signed({phi[j][PW-1], phi[j], CSPLIT'(0)}) + DETW'(plo[j]);
      end
      det   <= term[0] + term[1] + term[2];
      dneg  <= det[DETW-1];
      dmag  <= det[DETW-1] ? MAGW'(-det) : MAGW'(det);
      zero  <= (det == '0);
      c3    <= cof;
      c4    <= c3;
      c5    <= c4;
      cof_d <= c5;
    end
  end

endmodule

### hdl/mi3_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_lane
// One inverse element: rounded quotient of adjugate entry over determinant
// by a pipelined restoring division, one quotient bit per stage, then clip.
// ----------------------------------------------------------------------------
module mi3_lane import mi3_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  cof_t  adj,
  input  dmag_t dmag,
  input  logic  dneg,
  input  logic  zero,
  output res_t  res
);

  logic [REMW-1:0] rem [QW+1];
  logic [QW-1:0]   nlo [QW+1];
  logic [QW-1:0]   quo [QW+1];
  logic [DENW-1:0] den [QW+1];
  logic            neg [QW+1];
  logic            ovf [QW+1];
  logic            zer [QW+1];

  logic [CW-1:0]   aabs;
  logic [AMW-1:0]  am;
  logic [NW-1:0]   num;
  logic [DENW-1:0] den_in;
  logic [NW-QW-1:0] top_bits;

  // numerator |A|*2^33 + |D| over 2|D| rounds to nearest, ties away
  assign aabs     = adj[CW-1] ? CW'(-adj) : CW'(adj);
  assign am       = aabs[AMW-1:0];
  assign num      = {am, FRACSH'(0)} + NW'(dmag);
  assign den_in   = {dmag, 1'b0};
  assign top_bits = num[NW-1:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= REMW'(top_bits);
      nlo[0] <= num[QW-1:0];
      quo[0] <= '0;
      den[0] <= den_in;
      neg[0] <= adj[CW-1] ^ dneg;
      ovf[0] <= (REMW'(top_bits) >= den_in);
      zer[0] <= zero;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [REMW:0] t;
    logic [REMW:0] diff;
    logic          ge;

    assign t    = {rem[k], nlo[k][QW-1]};
    assign diff = t - {1'b0, den[k]};
    assign ge   = (t >= {1'b0, den[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[REMW-1:0] : t[REMW-1:0];
        nlo[k+1] <= {nlo[k][QW-2:0], 1'b0};
        quo[k+1] <= {quo[k][QW-2:0], ge};
        den[k+1] <= den[k];
        neg[k+1] <= neg[k];
        ovf[k+1] <= ovf[k];
        zer[k+1] <= zer[k];
      end
    end
  end

  logic [QW-1:0] q;
  logic [QW-1:0] qs;
  logic          clip;

  assign q    = quo[QW];
  assign clip = ovf[QW] | (neg[QW] ? (q > Q_NEG_LIM) : (q > Q_POS_LIM));
  assign qs   = neg[QW] ? QW'(-q) : q;

  always_ff @(posedge clk) begin
    if (en) begin
      res.sing <= zer[QW];
      if (zer[QW]) begin
        res.val <= '0;
        res.sat <= 1'b0;
      end else if (clip) begin
        res.val <= neg[QW] ? Q_MIN : Q_MAX;
        res.sat <= 1'b1;
      end else begin
        res.val <= qs[EW-1:0];
        res.sat <= 1'b0;
      end
    end
  end

endmodule

### hdl/mi3_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_merge
// Combines the lane results into one item, registers it and keeps a skid
// entry so the pipeline enable comes from a register; the pipeline holds
// only while that entry is full.
// ----------------------------------------------------------------------------
module mi3_merge import mi3_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  lane_valid,
  input  res_t  lane [NLANE],
  output logic  en,
  output logic  out_valid,
  input  logic  out_ready,
  output elem_t b    [NLANE],
  output logic  singular,
  output logic  saturated
);

  logic  pv;
  elem_t pb [NLANE];
  logic  psing;
  logic  psat;

  logic  skid_valid;
  elem_t sb [NLANE];
  logic  ssing;
  logic  ssat;

  logic  any_sat;

  always_comb begin
    any_sat = 1'b0;
    for (int i = 0; i < NLANE; i++) begin
      any_sat = any_sat | lane[i].sat;
    end
  end

  assign en = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv         <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (en) begin
        pv <= lane_valid;
        // park the waiting item
        if (pv && !out_ready) begin
          skid_valid <= 1'b1;
        end
      end else if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NLANE; i++) begin
        pb[i] <= lane[i].val;
      end
      psing <= lane[0].sing;
      psat  <= any_sat;
      sb    <= pb;
      ssing <= psing;
      ssat  <= psat;
    end
  end

  assign out_valid = skid_valid | pv;
  assign singular  = skid_valid ? ssing : psing;
  assign saturated = skid_valid ? ssat : psat;

  for (genvar i = 0; i < NLANE; i++) begin : g_out
    assign b[i] = skid_valid ? sb[i] : pb[i];
  end

endmodule

### hdl/mat3_inverse_adjugate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat3_inverse_adjugate
// 3x3 matrix inverse by the adjugate, Q8.16 in and out, saturating.
// ----------------------------------------------------------------------------
// Accepts one matrix per clock and returns the inverses in order, one result
// per clock, while the output skid entry is empty. Each matrix passes three
// cofactor stages and four determinant stages, then the nine division lanes,
// each a 25-stage restoring divider resolving one quotient bit per stage.
// A zero determinant gives all-zero elements with singular set; any element
// clipped to the Q8.16 range sets saturated.
module mat3_inverse_adjugate import mi3_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  elem_t a00,
  input  elem_t a01,
  input  elem_t a02,
  input  elem_t a10,
  input  elem_t a11,
  input  elem_t a12,
  input  elem_t a20,
  input  elem_t a21,
  input  elem_t a22,
  output logic  out_valid,
  input  logic  out_ready,
  output elem_t b00,
  output elem_t b01,
  output elem_t b02,
  output elem_t b10,
  output elem_t b11,
  output elem_t b12,
  output elem_t b20,
  output elem_t b21,
  output elem_t b22,
  output logic  singular,
  output logic  saturated
);

  logic               en;
  logic [LAT_CORE-1:0] vld;
  elem_t              a     [9];
  cof_t               cof   [9];
  elem_t              row0  [3];
  cof_t               cof_d [9];
  dmag_t              dmag;
  logic               dneg;
  logic               zero;
  res_t               lane  [NLANE];
  elem_t              b     [NLANE];

  assign in_ready = en;

  assign a = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT_CORE-2:0], in_valid};
    end
  end

  mi3_cofactor u_cofactor (
    .clk  (clk),
    .en   (en),
    .a    (a),
    .cof  (cof),
    .row0 (row0)
  );

  mi3_det u_det (
    .clk   (clk),
    .en    (en),
    .cof   (cof),
    .row0  (row0),
    .cof_d (cof_d),
    .dmag  (dmag),
    .dneg  (dneg),
    .zero  (zero)
  );

  // lane i holds adjugate entry i, the transposed cofactor
  for (genvar i = 0; i < NLANE; i++) begin : g_lane
    localparam int CIDX = (i % 3) * 3 + i / 3;
    mi3_lane u_lane (
      .clk  (clk),
      .en   (en),
      .adj  (cof_d[CIDX]),
      .dmag (dmag),
      .dneg (dneg),
      .zero (zero),
      .res  (lane[i])
    );
  end

  mi3_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .lane_valid (vld[LAT_CORE-1]),
    .lane       (lane),
    .en         (en),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .b          (b),
    .singular   (singular),
    .saturated  (saturated)
  );

  assign b00 = b[0];
  assign b01 = b[1];
  assign b02 = b[2];
  assign b10 = b[3];
  assign b11 = b[4];
  assign b12 = b[5];
  assign b20 = b[6];
  assign b21 = b[7];
  assign b22 = b[8];

endmodule

### hdl/mi3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_checker
// Port-level checks on the inverse block, bound to the top level.
// ----------------------------------------------------------------------------
module mi3_checker import mi3_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input elem_t b00,
  input elem_t b01,
  input elem_t b02,
  input elem_t b10,
  input elem_t b11,
  input elem_t b12,
  input elem_t b20,
  input elem_t b21,
  input elem_t b22,
  input logic  singular,
  input logic  saturated
);

  // a stalled result holds (checked on b00, b11, b22, b01, b12 and both flags)
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(b00) && $stable(b11) && $stable(b22)
      && $stable(b01) && $stable(b12) && $stable(singular) && $stable(saturated))
    else $error("stalled result changed");

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> !saturated && b00 == '0 && b01 == '0 && b02 == '0
      && b10 == '0 && b11 == '0 && b12 == '0 && b20 == '0 && b21 == '0 && b22 == '0)
    else $error("singular result not cleared");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with no result waiting");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind mat3_inverse_adjugate mi3_checker u_mi3_checker (.*);

### sim/mat3_inverse_adjugate_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat3_inverse_adjugate_test
// Self-checking bench for the 3x3 adjugate inverse.
// ----------------------------------------------------------------------------
// An initial block queues matrices: a directed set first, then random phases.
// A clocked driver offers them on the valid/ready input, and a clocked monitor
// compares each returned inverse with the exact-integer prediction taken when
// the matrix was accepted. The idling of both sides changes from phase to phase.
module mat3_inverse_adjugate_test;
  import mi3_pkg::*;

  typedef struct {
    elem_t a [9];
  } matrix_t;

  typedef struct {
    elem_t b [9];
    logic  sing;
    logic  sat;
  } inverse_t;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  elem_t drv_a [9];
  logic  out_valid;
  logic  out_ready = 1'b0;
  elem_t got_b [9];
  logic  singular;
  logic  saturated;

  matrix_t  pending_mats [$];
  inverse_t expected_invs [$];
  matrix_t  cur_mat;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_requests = 0;
  int       hold_served = 0;
  int       hold_left = 0;
  int       cycles = 0;
  int       errors = 0;

  initial for (int i = 0; i < 9; i++) drv_a[i] = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  mat3_inverse_adjugate i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .a00(drv_a[0]), .a01(drv_a[1]), .a02(drv_a[2]),
    .a10(drv_a[3]), .a11(drv_a[4]), .a12(drv_a[5]),
    .a20(drv_a[6]), .a21(drv_a[7]), .a22(drv_a[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .b00(got_b[0]), .b01(got_b[1]), .b02(got_b[2]),
    .b10(got_b[3]), .b11(got_b[4]), .b12(got_b[5]),
    .b20(got_b[6]), .b21(got_b[7]), .b22(got_b[8]),
    .singular(singular), .saturated(saturated)
  );

  // Exact inverse: cofactors, determinant, then round-half-away division and clipping.
  function automatic inverse_t invert(matrix_t m);
    longint                cof [9];
    longint                adj;
    logic signed [127:0]   det;
    logic [127:0]          dmag, num, quo;
    logic                  neg;
    inverse_t              r;
    cof[0] = longint'(m.a[4]) * m.a[8] - longint'(m.a[5]) * m.a[7];
    cof[1] = longint'(m.a[5]) * m.a[6] - longint'(m.a[3]) * m.a[8];
    cof[2] = longint'(m.a[3]) * m.a[7] - longint'(m.a[4]) * m.a[6];
    cof[3] = longint'(m.a[2]) * m.a[7] - longint'(m.a[1]) * m.a[8];
    cof[4] = longint'(m.a[0]) * m.a[8] - longint'(m.a[2]) * m.a[6];
    cof[5] = longint'(m.a[1]) * m.a[6] - longint'(m.a[0]) * m.a[7];
    cof[6] = longint'(m.a[1]) * m.a[5] - longint'(m.a[2]) * m.a[4];
    cof[7] = longint'(m.a[2]) * m.a[3] - longint'(m.a[0]) * m.a[5];
    cof[8] = longint'(m.a[0]) * m.a[4] - longint'(m.a[1]) * m.a[3];
    det = 128'(signed'(m.a[0])) * 128'(cof[0]) + 128'(signed'(m.a[1])) * 128'(cof[1])
        + 128'(signed'(m.a[2])) * 128'(cof[2]);
    r.sing = (det == 0);
    r.sat  = 1'b0;
    for (int i = 0; i < 9; i++) r.b[i] = '0;
    if (!r.sing) begin
      dmag = det < 0 ? 128'(-det) : 128'(det);
      for (int i = 0; i < 9; i++) begin
        adj = cof[(i % 3) * 3 + i / 3];
        num = 128'(adj < 0 ? -adj : adj) << 33;
        quo = (num + dmag) / (dmag << 1);
        neg = (adj < 0) != (det < 0);
        if (neg) begin
          if (quo > 128'd8388608) begin
            quo = 128'd8388608;
            r.sat = 1'b1;
          end
          r.b[i] = elem_t'(-quo);
        end else begin
          if (quo > 128'd8388607) begin
            quo = 128'd8388607;
            r.sat = 1'b1;
          end
          r.b[i] = elem_t'(quo);
        end
      end
    end
    return r;
  endfunction

  // Driver: hold an offered item until taken, then advance or idle.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) expected_invs.push_back(invert(cur_mat));
      if (!(in_valid && !in_ready)) begin
        if (pending_mats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_mat = pending_mats.pop_front();
          for (int i = 0; i < 9; i++) drv_a[i] <= cur_mat.a[i];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served <= hold_served + 1;
        hold_left   <= HOLD_CYCLES;
        out_ready   <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    inverse_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_invs.size() == 0) begin
        $error("result with no matrix outstanding");
        errors++;
      end else begin
        want = expected_invs.pop_front();
        for (int i = 0; i < 9; i++)
          if (got_b[i] !== want.b[i]) begin
            $error("b%0d%0d: expected %0d, got %0d", i / 3, i % 3, want.b[i], got_b[i]);
            errors++;
          end
        if (singular !== want.sing) begin
          $error("singular: expected %0b, got %0b", want.sing, singular);
          errors++;
        end
        if (saturated !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("mat3_inverse_adjugate regression: fail");
      $finish;
    end
  end

  function automatic matrix_t diag(elem_t d0, elem_t d1, elem_t d2);
    matrix_t m;
    for (int i = 0; i < 9; i++) m.a[i] = '0;
    m.a[0] = d0;
    m.a[4] = d1;
    m.a[8] = d2;
    return m;
  endfunction

  function automatic matrix_t fill(elem_t v);
    matrix_t m;
    for (int i = 0; i < 9; i++) m.a[i] = v;
    return m;
  endfunction

  function automatic elem_t near_one();
    return elem_t'($signed($urandom_range(262144)) - 131072);
  endfunction

  // Mostly well-conditioned matrices, with singular ones and raw noise mixed in.
  function automatic matrix_t random_matrix();
    matrix_t m;
    int      kind, r, s;
    kind = $urandom_range(99);
    for (int i = 0; i < 9; i++) m.a[i] = elem_t'($urandom);
    if (kind < 45) begin
      for (int i = 0; i < 9; i++) m.a[i] = near_one();
    end else if (kind < 60) begin
      m = diag(near_one(), near_one(), near_one());
      for (int i = 0; i < 9; i++)
        if ($urandom_range(3) == 0) m.a[i] = elem_t'($urandom_range(4095));
    end else if (kind < 75) begin
      // set each entry of one row to the matching entry of another, its negation or zero
      for (int i = 0; i < 9; i++) m.a[i] = near_one();
      r = $urandom_range(2);
      s = (r + 1 + $urandom_range(1)) % 3;
      for (int j = 0; j < 3; j++)
        case ($urandom_range(2))
          0: m.a[s*3+j] = m.a[r*3+j];
          1: m.a[s*3+j] = -m.a[r*3+j];
          default: m.a[s*3+j] = '0;
        endcase
    end else if (kind < 85) begin
      for (int i = 0; i < 9; i++) m.a[i] = elem_t'($signed($urandom_range(64)) - 32);
    end
    return m;
  endfunction

  task automatic wait_drained();
    wait (pending_mats.size() == 0 && expected_invs.size() == 0 && !in_valid);
  endtask

  initial begin
    matrix_t m;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: identity, zero, extremes, signs, singular and clipping cases
    pending_mats.push_back(diag(24'sh010000, 24'sh010000, 24'sh010000));
    pending_mats.push_back(fill('0));
    pending_mats.push_back(fill(Q_MAX));
    pending_mats.push_back(fill(Q_MIN));
    pending_mats.push_back(diag(Q_MAX, Q_MAX, Q_MAX));
    pending_mats.push_back(diag(Q_MIN, Q_MIN, Q_MIN));
    pending_mats.push_back(diag(Q_MAX, Q_MIN, 24'sh010000));
    pending_mats.push_back(diag(24'sd1, 24'sd1, 24'sd1));
    pending_mats.push_back(diag(-24'sd1, 24'sd1, 24'sd1));
    pending_mats.push_back(diag(24'sh020000, -24'sh008000, 24'sh030000));
    pending_mats.push_back(diag(24'sh000300, 24'sh010000, 24'sh010000));
    pending_mats.push_back(diag(24'sh00FFFF, 24'sh00FFFF, 24'sh00FFFF));
    pending_mats.push_back(diag(24'sh030000, 24'sh030000, 24'sh030000));
    m = fill('0);
    m.a[1] = 24'sh010000; m.a[5] = 24'sh010000; m.a[6] = 24'sh010000;
    pending_mats.push_back(m);
    m = fill(24'sh010000);
    m.a[0] = 24'sh020000;
    pending_mats.push_back(m);
    m = fill('0);
    for (int i = 0; i < 9; i++) m.a[i] = elem_t'((i + 1) * 65536);
    pending_mats.push_back(m);
    m.a[8] = 24'sh0A0000;
    pending_mats.push_back(m);
    m = fill(Q_MAX);
    m.a[0] = Q_MIN; m.a[4] = Q_MIN; m.a[8] = Q_MIN;
    pending_mats.push_back(m);
    m = fill(24'sh555555);
    m.a[3] = 24'shAAAAAA; m.a[7] = 24'shAAAAAA; m.a[2] = 24'sh000001;
    pending_mats.push_back(m);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      for (int k = 0; k < 400; k++) pending_mats.push_back(random_matrix());
      if (phase == 0) begin
        // long output hold-off while the sender keeps offering
        @(negedge clk);
        hold_requests = hold_requests + 1;
      end
      wait_drained();
      if (phase == 0 || phase == 2) begin
        // stretch of no idling after the first and third phases
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int k = 0; k < 40; k++) pending_mats.push_back(random_matrix());
        wait_drained();
      end
    end

    repeat (LAT_CORE + 20) @(posedge clk);
    if (errors == 0) $display("mat3_inverse_adjugate regression: pass");
    else $display("mat3_inverse_adjugate regression: fail");
    $finish;
  end

endmodule
